FILE: rtl/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every clock edge, masked while reset is high
`define AVC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("parser check failed");
// Check prop on every clock edge, reset included
`define AVC_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("parser check failed");
`else
`define AVC_ASSERT(lbl, clk, rst, prop)
`define AVC_ASSERT_ALL(lbl, clk, prop)
`endif
`endif

FILE: rtl/avccr_pkg.sv
// Types, codes and constants for the AVC configuration record parser.
// No dependencies; used by the core, the top level and the testbench.
package avccr_pkg;

  // Parse phases
  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_SPS_HI   = 4'd1,
    PH_SPS_LO   = 4'd2,
    PH_SPS_DATA = 4'd3,
    PH_PPS_CNT  = 4'd4,
    PH_PPS_HI   = 4'd5,
    PH_PPS_LO   = 4'd6,
    PH_PPS_DATA = 4'd7,
    PH_TRAIL    = 4'd8,
    PH_SKIP     = 4'd9
  } phase_t;

  // Byte classes
  localparam logic [2:0] CLS_HDR = 3'd0;
  localparam logic [2:0] CLS_SPS = 3'd1;
  localparam logic [2:0] CLS_PPS = 3'd2;
  localparam logic [2:0] CLS_TRL = 3'd3;
  localparam logic [2:0] CLS_SKP = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_VERSION = 3'd1;
  localparam logic [2:0] ERR_SPS_CNT = 3'd2;
  localparam logic [2:0] ERR_PPS_CNT = 3'd3;
  localparam logic [2:0] ERR_TRUNC   = 3'd4;

  // Record constants
  localparam logic [7:0] RECORD_VERSION = 8'h01;
  localparam logic [7:0] COUNT_ONE      = 8'h01;
  localparam logic [7:0] SPS_COUNT_MASK = 8'h1f;
  localparam logic [2:0] HDR_POS_LSIZE  = 3'd4;
  localparam logic [2:0] HDR_POS_SPSCNT = 3'd5;

  // One result item
  typedef struct packed {
    logic [2:0]  byte_class;
    logic [7:0]  payload_byte;
    logic        payload_end;
    logic [2:0]  nalu_length_size;
    logic [15:0] sps_length;
    logic [15:0] pps_length;
    logic [2:0]  error_code;
    logic        record_done;
  } result_t;

  // Core status seen by the top level
  typedef struct packed {
    phase_t     phase;
    logic [2:0] error;
  } status_t;

endpackage

FILE: rtl/avccr_if.sv
// Valid/ready channel interfaces for record bytes and parse results.
// Depends on nothing; field widths follow the item definitions.
interface avccr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface avccr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_class;
  logic [7:0]  payload_byte;
  logic        payload_end;
  logic [2:0]  nalu_length_size;
  logic [15:0] sps_length;
  logic [15:0] pps_length;
  logic [2:0]  error_code;
  logic        record_done;

  modport source (output valid, output byte_class, output payload_byte,
                  output payload_end, output nalu_length_size, output sps_length,
                  output pps_length, output error_code, output record_done,
                  input ready);
  modport sink   (input valid, input byte_class, input payload_byte,
                  input payload_end, input nalu_length_size, input sps_length,
                  input pps_length, input error_code, input record_done,
                  output ready);
endinterface

FILE: rtl/avccr_core.sv
// Parser state registers and per-byte step logic.
// Depends on avccr_pkg; computes one result per accepted byte.
module avccr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output avccr_pkg::result_t  result,
  output avccr_pkg::status_t  status
);

  avccr_pkg::phase_t phase, phase_next;
  logic [2:0]  hdr_pos, hdr_pos_next;
  logic [15:0] remaining, remaining_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [2:0]  lsize, lsize_next;
  logic [15:0] sps_len, sps_len_next;
  logic [15:0] pps_len, pps_len_next;
  logic [2:0]  error, error_next;
  logic [2:0]  cls;
  logic        pend;
  logic        complete;

  // Step logic for one byte
  always_comb begin
    phase_next     = phase;
    hdr_pos_next   = hdr_pos;
    remaining_next = remaining;
    len_hi_next    = len_hi;
    lsize_next     = lsize;
    sps_len_next   = sps_len;
    pps_len_next   = pps_len;
    error_next     = error;
    cls            = avccr_pkg::CLS_HDR;
    pend           = 1'b0;
    case (phase)
      avccr_pkg::PH_HEADER: begin
        if (hdr_pos == 3'd0 && data_byte != avccr_pkg::RECORD_VERSION) begin
          if (error == avccr_pkg::ERR_NONE) error_next = avccr_pkg::ERR_VERSION;
          phase_next = avccr_pkg::PH_SKIP;
        end else if (hdr_pos == avccr_pkg::HDR_POS_LSIZE) begin
          lsize_next = {1'b0, data_byte[1:0]} + 3'd1;
        end else if (hdr_pos == avccr_pkg::HDR_POS_SPSCNT) begin
          if ((data_byte & avccr_pkg::SPS_COUNT_MASK) != avccr_pkg::COUNT_ONE) begin
            if (error == avccr_pkg::ERR_NONE) error_next = avccr_pkg::ERR_SPS_CNT;
            phase_next = avccr_pkg::PH_SKIP;
          end else begin
            phase_next = avccr_pkg::PH_SPS_HI;
          end
        end
        if (hdr_pos < avccr_pkg::HDR_POS_SPSCNT) hdr_pos_next = hdr_pos + 3'd1;
      end
      avccr_pkg::PH_SPS_HI: begin
        len_hi_next = data_byte;
        phase_next  = avccr_pkg::PH_SPS_LO;
      end
      avccr_pkg::PH_SPS_LO: begin
        sps_len_next   = {len_hi, data_byte};
        remaining_next = {len_hi, data_byte};
        phase_next     = ({len_hi, data_byte} == 16'd0) ? avccr_pkg::PH_PPS_CNT
                                                        : avccr_pkg::PH_SPS_DATA;
      end
      avccr_pkg::PH_SPS_DATA: begin
        cls            = avccr_pkg::CLS_SPS;
        remaining_next = remaining - 16'd1;
        if (remaining == 16'd1) begin
          pend       = 1'b1;
          phase_next = avccr_pkg::PH_PPS_CNT;
        end
      end
      avccr_pkg::PH_PPS_CNT: begin
        if (data_byte != avccr_pkg::COUNT_ONE) begin
          if (error == avccr_pkg::ERR_NONE) error_next = avccr_pkg::ERR_PPS_CNT;
          phase_next = avccr_pkg::PH_SKIP;
        end else begin
          phase_next = avccr_pkg::PH_PPS_HI;
        end
      end
      avccr_pkg::PH_PPS_HI: begin
        len_hi_next = data_byte;
        phase_next  = avccr_pkg::PH_PPS_LO;
      end
      avccr_pkg::PH_PPS_LO: begin
        pps_len_next   = {len_hi, data_byte};
        remaining_next = {len_hi, data_byte};
        phase_next     = ({len_hi, data_byte} == 16'd0) ? avccr_pkg::PH_TRAIL
                                                        : avccr_pkg::PH_PPS_DATA;
      end
      avccr_pkg::PH_PPS_DATA: begin
        cls            = avccr_pkg::CLS_PPS;
        remaining_next = remaining - 16'd1;
        if (remaining == 16'd1) begin
          pend       = 1'b1;
          phase_next = avccr_pkg::PH_TRAIL;
        end
      end
      avccr_pkg::PH_TRAIL: begin
        cls = avccr_pkg::CLS_TRL;
      end
      default: begin
        cls        = avccr_pkg::CLS_SKP;
        phase_next = avccr_pkg::PH_SKIP;
      end
    endcase

    // End-of-record checks
    complete = (phase_next == avccr_pkg::PH_TRAIL);
    if (last_byte && !complete && error_next == avccr_pkg::ERR_NONE) begin
      error_next = avccr_pkg::ERR_TRUNC;
    end
  end

  // Result for the current byte
  always_comb begin
    result.byte_class       = cls;
    result.payload_byte     = data_byte;
    result.payload_end      = pend;
    result.nalu_length_size = lsize_next;
    result.sps_length       = sps_len_next;
    result.pps_length       = pps_len_next;
    result.error_code       = error_next;
    result.record_done      = last_byte && complete && error_next == avccr_pkg::ERR_NONE;
  end

  assign status.phase = phase;
  assign status.error = error;

  // State registers; the last byte of a record returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase     <= avccr_pkg::PH_HEADER;
      hdr_pos   <= 3'd0;
      remaining <= 16'd0;
      len_hi    <= 8'd0;
      lsize     <= 3'd1;
      sps_len   <= 16'd0;
      pps_len   <= 16'd0;
      error     <= avccr_pkg::ERR_NONE;
    end else if (step) begin
      phase     <= phase_next;
      hdr_pos   <= hdr_pos_next;
      remaining <= remaining_next;
      len_hi    <= len_hi_next;
      lsize     <= lsize_next;
      sps_len   <= sps_len_next;
      pps_len   <= pps_len_next;
      error     <= error_next;
    end
  end

endmodule

FILE: rtl/avc_config_record_parser.sv
// AVC decoder configuration record parser: one result item per record byte.
// A result is registered and is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output keeps up; the result register is refilled while it drains.
// Input stalls only while a result waits and the downstream ready is low.
// Synchronous active-high reset clears parser state and the result valid flag.
`include "assert_macros.svh"

module avc_config_record_parser (
  input  logic         clk,
  input  logic         rst,
  avccr_in_if.sink     record,
  avccr_out_if.source  parsed
);

  avccr_pkg::result_t step_res;
  avccr_pkg::result_t res;
  avccr_pkg::status_t status;
  logic               res_valid;
  logic               accept;

  // Input is taken whenever the result register is free or draining
  assign record.ready = !res_valid || parsed.ready;
  assign accept       = record.valid && record.ready;

  avccr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .data_byte (record.data_byte),
    .last_byte (record.last_byte),
    .result    (step_res),
    .status    (status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (parsed.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= step_res;
    end
  end

  assign parsed.valid            = res_valid;
  assign parsed.byte_class       = res.byte_class;
  assign parsed.payload_byte     = res.payload_byte;
  assign parsed.payload_end      = res.payload_end;
  assign parsed.nalu_length_size = res.nalu_length_size;
  assign parsed.sps_length       = res.sps_length;
  assign parsed.pps_length       = res.pps_length;
  assign parsed.error_code       = res.error_code;
  assign parsed.record_done      = res.record_done;

  // Checks
  `AVC_ASSERT(a_last_resets, clk, rst, (accept && record.last_byte) |=> (status.phase == avccr_pkg::PH_HEADER && status.error == avccr_pkg::ERR_NONE))
  `AVC_ASSERT(a_err_skips, clk, rst, (status.error != avccr_pkg::ERR_NONE) |-> (status.phase == avccr_pkg::PH_SKIP))
  `AVC_ASSERT(a_done_clean, clk, rst, (parsed.valid && parsed.record_done) |-> (parsed.error_code == avccr_pkg::ERR_NONE))
  `AVC_ASSERT(a_end_payload, clk, rst, (parsed.valid && parsed.payload_end) |-> (parsed.byte_class == avccr_pkg::CLS_SPS || parsed.byte_class == avccr_pkg::CLS_PPS))

endmodule

FILE: verif/avc_config_record_parser_tb.sv
// Testbench for avc_config_record_parser: directed and random configuration records.
// Depends on avccr_pkg, the avccr_in_if/avccr_out_if interfaces and the parser RTL.
// A scoreboard class predicts every parse result and checks the results field by field.
module avc_config_record_parser_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 120;

  logic clk = 1'b0;
  logic rst;

  avccr_in_if  record_ch();
  avccr_out_if parsed_ch();

  avc_config_record_parser dut (
    .clk    (clk),
    .rst    (rst),
    .record (record_ch),
    .parsed (parsed_ch)
  );

  // Predicts the parse of each accepted byte and checks the results in order
  class record_scoreboard;
    avccr_pkg::phase_t  phase;
    logic [2:0]         hdr_pos;
    logic [15:0]        remaining;
    logic [7:0]         len_hi;
    logic [2:0]         lsize;
    logic [15:0]        sps_len;
    logic [15:0]        pps_len;
    logic [2:0]         err;
    avccr_pkg::result_t expected_parses[$];
    int                 mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      phase     = avccr_pkg::PH_HEADER;
      hdr_pos   = '0;
      remaining = '0;
      len_hi    = '0;
      lsize     = 3'd1;
      sps_len   = '0;
      pps_len   = '0;
      err       = avccr_pkg::ERR_NONE;
    endfunction

    // First error sticks; parsing skips to the end of the record
    function void flag_error(logic [2:0] code);
      if (err == avccr_pkg::ERR_NONE) err = code;
      phase = avccr_pkg::PH_SKIP;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      avccr_pkg::result_t want;
      logic               complete;
      want = '0;
      want.byte_class = avccr_pkg::CLS_HDR;
      case (phase)
        avccr_pkg::PH_HEADER: begin
          if (hdr_pos == 3'd0 && b != avccr_pkg::RECORD_VERSION) begin
            flag_error(avccr_pkg::ERR_VERSION);
          end else if (hdr_pos == avccr_pkg::HDR_POS_LSIZE) begin
            lsize = {1'b0, b[1:0]} + 3'd1;
          end else if (hdr_pos == avccr_pkg::HDR_POS_SPSCNT) begin
            if ((b & avccr_pkg::SPS_COUNT_MASK) != avccr_pkg::COUNT_ONE)
              flag_error(avccr_pkg::ERR_SPS_CNT);
            else phase = avccr_pkg::PH_SPS_HI;
          end
          if (hdr_pos < avccr_pkg::HDR_POS_SPSCNT) hdr_pos = hdr_pos + 3'd1;
        end
        avccr_pkg::PH_SPS_HI: begin
          len_hi = b;
          phase  = avccr_pkg::PH_SPS_LO;
        end
        avccr_pkg::PH_SPS_LO: begin
          sps_len   = {len_hi, b};
          remaining = sps_len;
          phase     = (sps_len == 16'd0) ? avccr_pkg::PH_PPS_CNT : avccr_pkg::PH_SPS_DATA;
        end
        avccr_pkg::PH_SPS_DATA: begin
          want.byte_class = avccr_pkg::CLS_SPS;
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) begin
            want.payload_end = 1'b1;
            phase = avccr_pkg::PH_PPS_CNT;
          end
        end
        avccr_pkg::PH_PPS_CNT: begin
          if (b != avccr_pkg::COUNT_ONE) flag_error(avccr_pkg::ERR_PPS_CNT);
          else phase = avccr_pkg::PH_PPS_HI;
        end
        avccr_pkg::PH_PPS_HI: begin
          len_hi = b;
          phase  = avccr_pkg::PH_PPS_LO;
        end
        avccr_pkg::PH_PPS_LO: begin
          pps_len   = {len_hi, b};
          remaining = pps_len;
          phase     = (pps_len == 16'd0) ? avccr_pkg::PH_TRAIL : avccr_pkg::PH_PPS_DATA;
        end
        avccr_pkg::PH_PPS_DATA: begin
          want.byte_class = avccr_pkg::CLS_PPS;
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) begin
            want.payload_end = 1'b1;
            phase = avccr_pkg::PH_TRAIL;
          end
        end
        avccr_pkg::PH_TRAIL: begin
          want.byte_class = avccr_pkg::CLS_TRL;
        end
        default: begin
          want.byte_class = avccr_pkg::CLS_SKP;
          phase = avccr_pkg::PH_SKIP;
        end
      endcase

      // Record end: truncation unless the PPS payload was fully consumed
      complete = (phase == avccr_pkg::PH_TRAIL);
      if (last && !complete && err == avccr_pkg::ERR_NONE) err = avccr_pkg::ERR_TRUNC;
      want.payload_byte     = b;
      want.nalu_length_size = lsize;
      want.sps_length       = sps_len;
      want.pps_length       = pps_len;
      want.error_code       = err;
      want.record_done      = last && complete && err == avccr_pkg::ERR_NONE;
      expected_parses = {expected_parses, want};
      if (last) clear_state();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_parse(avccr_pkg::result_t got);
      avccr_pkg::result_t want;
      if (expected_parses.size() == 0) begin
        $display("%0t: result %0h arrived with none expected", $time, got);
        mismatches++;
        return;
      end
      want = expected_parses.pop_front();
      compare_field("byte_class", want.byte_class, got.byte_class);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_end", want.payload_end, got.payload_end);
      compare_field("nalu_length_size", want.nalu_length_size, got.nalu_length_size);
      compare_field("sps_length", want.sps_length, got.sps_length);
      compare_field("pps_length", want.pps_length, got.pps_length);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("record_done", want.record_done, got.record_done);
    endfunction
  endclass

  record_scoreboard sb = new();
  logic [7:0] record_bytes[$];
  int         sent_items = 0;
  int         send_idle_pct = 26;
  int         recv_idle_pct = 88;
  bit         stall_request = 1'b0;
  int         cycle_count = 0;

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Add one byte at the end of the record being built
  function automatic void append_byte(input logic [7:0] b);
    record_bytes = {record_bytes, b};
  endfunction

  // Offer one byte; returns at the edge where it is accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      record_ch.valid <= 1'b0;
      @(posedge clk);
    end
    record_ch.valid     <= 1'b1;
    record_ch.data_byte <= b;
    record_ch.last_byte <= last;
    do @(negedge clk); while (!record_ch.ready);
    @(posedge clk);
    sb.note_byte(b, last);
    sent_items++;
  endtask

  task automatic send_record();
    foreach (record_bytes[i]) send_byte(record_bytes[i], i == record_bytes.size() - 1);
  endtask

  // Well-formed record with random header and payload content
  task automatic make_record(input int sps, input int pps, input int trail);
    record_bytes = {};
    append_byte(avccr_pkg::RECORD_VERSION);
    repeat (4) append_byte(8'($urandom));
    append_byte((8'($urandom) & ~avccr_pkg::SPS_COUNT_MASK) | avccr_pkg::COUNT_ONE);
    append_byte(8'(sps >> 8));
    append_byte(8'(sps));
    repeat (sps) append_byte(8'($urandom));
    append_byte(avccr_pkg::COUNT_ONE);
    append_byte(8'(pps >> 8));
    append_byte(8'(pps));
    repeat (pps) append_byte(8'($urandom));
    repeat (trail) append_byte(8'($urandom));
  endtask

  // Mostly well-formed records; the rest truncated, corrupted or noise
  task automatic random_record();
    int kind;
    int sps;
    int pps;
    int cut;
    kind = $urandom_range(99);
    sps  = ($urandom_range(59) == 0) ? $urandom_range(256, 270) : $urandom_range(8);
    pps  = ($urandom_range(59) == 0) ? $urandom_range(256, 270) : $urandom_range(8);
    make_record(sps, pps, $urandom_range(3));
    if (kind < 65) begin
      // left well-formed
    end else if (kind < 77) begin
      cut = $urandom_range(1, record_bytes.size() - 1);
      while (record_bytes.size() > cut) void'(record_bytes.pop_back());
    end else if (kind < 87) begin
      case ($urandom_range(2))
        0:       record_bytes[0] = 8'($urandom);
        1:       record_bytes[5] = 8'($urandom);
        default: record_bytes[8 + sps] = 8'($urandom);
      endcase
    end else if (kind < 94) begin
      // declared length out of step with the payload, usually far too long
      if ($urandom_range(1)) begin
        record_bytes[6] = 8'($urandom);
        record_bytes[7] = 8'($urandom);
      end else begin
        record_bytes[9 + sps]  = 8'($urandom);
        record_bytes[10 + sps] = 8'($urandom);
      end
    end else begin
      record_bytes = {};
      repeat ($urandom_range(1, 10)) append_byte(8'($urandom));
    end
    send_record();
  endtask

  // Sender goes quiet until every expected result has arrived
  task automatic wait_drained();
    record_ch.valid <= 1'b0;
    while (sb.expected_parses.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int target);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent_items < target) random_record();
  endtask

  // Result side: random ready, one long hold on request, check at mid-cycle
  initial begin
    int                 hold_left;
    avccr_pkg::result_t got;
    hold_left = 0;
    parsed_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        stall_request = 1'b0;
      end
      if (rst) begin
        parsed_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        parsed_ch.ready <= 1'b0;
      end else begin
        parsed_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(negedge clk);
      if (!rst && parsed_ch.valid === 1'b1 && parsed_ch.ready === 1'b1) begin
        got = {parsed_ch.byte_class, parsed_ch.payload_byte, parsed_ch.payload_end,
               parsed_ch.nalu_length_size, parsed_ch.sps_length, parsed_ch.pps_length,
               parsed_ch.error_code, parsed_ch.record_done};
        sb.check_parse(got);
      end
    end
  end

  // Stimulus
  initial begin
    rst                 <= 1'b1;
    record_ch.valid     <= 1'b0;
    record_ch.data_byte <= '0;
    record_ch.last_byte <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bad version byte alone, then a record cut after its version byte
    record_bytes = {8'hff};
    send_record();
    record_bytes = {avccr_pkg::RECORD_VERSION};
    send_record();
    // Complete record, extreme bytes, 4-byte NAL lengths, one trailing byte
    record_bytes = {avccr_pkg::RECORD_VERSION, 8'hff, 8'h00, 8'hff, 8'hff, 8'he1,
                    8'h00, 8'h01, 8'haa, avccr_pkg::COUNT_ONE, 8'h00, 8'h01, 8'h55,
                    8'h00};
    send_record();
    // SPS count of two, followed by a skipped byte
    record_bytes = {avccr_pkg::RECORD_VERSION, 8'h00, 8'h00, 8'h00, 8'hfc, 8'he2, 8'h55};
    send_record();

    stall_request = 1'b1;
    run_phase(26, 88, 600);
    wait_drained();
    run_phase(88, 26, 1200);
    run_phase(0, 0, 1800);

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_parses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
